### hw/rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants for the sprite screen projection block
// Fixed-point format, divider lane layout, status codes and register indexes.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int FRAC_BITS = 16;

  // Quotient bits produced by the camera-space divider chain and the screen
  // divider chain. Larger quotients are flagged as overflow before the chain.
  localparam int QA  = 34;
  localparam int QB  = 24;
  localparam int QW  = QA;
  localparam int DVW = 64;
  localparam int RW  = 65 + ((FRAC_BITS > QA) ? FRAC_BITS : QA);
  localparam int SHW = 7;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0]  REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0]  REG_SCREEN_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET       = CFG_DATA_W'(640);
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET      = CFG_DATA_W'(480);

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SINGULAR   = 2'd1,
    ST_ZERO_DEPTH = 2'd2
  } status_t;

  // One lane of a restoring divider: partial remainder, divisor, quotient.
  typedef struct packed {
    logic [RW-1:0]  rem;
    logic [DVW-1:0] dvs;
    logic [QW-1:0]  quo;
  } lane_t;

  // Context that travels with a word through a divider chain.
  typedef struct packed {
    status_t     status;
    logic [31:0] lat;
    logic [31:0] dep;
    logic        neg0;
    logic        neg1;
    logic        ovf0;
    logic        ovf1;
  } side_t;

  // One restoring step: try to subtract the divisor shifted to this bit.
  function automatic lane_t div_step(lane_t ln, logic [SHW-1:0] sh);
    logic [RW:0] sub;
    lane_t       res;
    sub = {1'b0, ln.rem} - ({1'b0, RW'(ln.dvs)} << sh);
    res = ln;
    if (!sub[RW]) begin
      res.rem = sub[RW-1:0];
    end
    res.quo = {ln.quo[QW-2:0], ~sub[RW]};
    return res;
  endfunction

endpackage

### hw/rtl/ssp_div_cell.sv
// ----------------------------------------------------------------------------
// ssp_div_cell: one quotient bit of two divider lanes
// Each cell retires one bit of both lanes and passes the word to the next cell.
// ----------------------------------------------------------------------------
module ssp_div_cell import ssp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [SHW-1:0] sh,
  input  logic           vld_i,
  input  lane_t          lane0_i,
  input  lane_t          lane1_i,
  input  side_t          side_i,
  output logic           vld_o,
  output lane_t          lane0_o,
  output lane_t          lane1_o,
  output side_t          side_o
);

  logic  vld_r;
  lane_t lane0_r;
  lane_t lane1_r;
  side_t side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_i) begin
      lane0_r <= div_step(lane0_i, sh);
      lane1_r <= div_step(lane1_i, sh);
      side_r  <= side_i;
    end
  end

  assign vld_o   = vld_r;
  assign lane0_o = lane0_r;
  assign lane1_o = lane1_r;
  assign side_o  = side_r;

endmodule

### hw/rtl/sprite_screen_projection_top.sv
// ----------------------------------------------------------------------------
// sprite_screen_projection_top: billboard sprite projection to screen bounds
// Camera-space transform, projection, span size and clipped drawing bounds.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one word per sprite: camera position, look
// direction, camera plane and sprite position, all signed fixed point.
// The output channel returns one word per input word, in order.
// The cfg channel writes screen_width (index 0) and screen_height (index 1);
// it is always ready and should be written only while the block is empty.
// Throughput is one word per cycle while the output is not stalled. The
// pipeline is five setup stages, a 34-cell divider chain for lateral and
// depth, five stages to set up the screen division, a 24-cell divider chain
// for column and span, one saturation stage and the output register.
// The divider chains make up most of the pipeline.
// A stall on the output holds the output word; stages behind it keep moving
// until they meet a full stage, so empty stages are filled while stalled.
// Reset empties the pipeline and restores 640 x 480.
// ----------------------------------------------------------------------------
module sprite_screen_projection_top import ssp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    in_cam_x,
  input  logic signed [31:0]    in_cam_y,
  input  logic signed [31:0]    in_look_x,
  input  logic signed [31:0]    in_look_y,
  input  logic signed [31:0]    in_plane_vec_x,
  input  logic signed [31:0]    in_plane_vec_y,
  input  logic signed [31:0]    in_obj_x,
  input  logic signed [31:0]    in_obj_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_lateral,
  output logic signed [31:0]    out_depth,
  output logic signed [23:0]    out_screen_center_x,
  output logic [22:0]           out_span_size,
  output logic [11:0]           out_top_row,
  output logic [11:0]           out_bottom_row,
  output logic [22:0]           out_left_col,
  output logic signed [23:0]    out_right_col,
  output logic [1:0]            out_status
);

  function automatic logic [31:0] sat_diff(logic signed [31:0] a, logic signed [31:0] b);
    logic [32:0] d;
    logic [31:0] res;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      res = d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res = d[31:0];
    end
    return res;
  endfunction

  function automatic logic [63:0] mag65(logic [64:0] v);
    logic [64:0] t;
    t = v[64] ? (~v + 65'd1) : v;
    return t[63:0];
  endfunction

  function automatic logic [31:0] sat_q32(logic [QW-1:0] q, logic neg, logic ovf);
    logic [31:0] res;
    if (neg) begin
      if (ovf || q > QW'(33'h0_8000_0000)) res = 32'h8000_0000;
      else res = -q[31:0];
    end else begin
      if (ovf || q > QW'(32'h7FFF_FFFF)) res = 32'h7FFF_FFFF;
      else res = q[31:0];
    end
    return res;
  endfunction

  function automatic logic [23:0] sat_q24(logic [QW-1:0] q, logic neg, logic ovf);
    logic [23:0] res;
    if (neg) begin
      if (ovf || q > QW'(24'h80_0000)) res = 24'h80_0000;
      else res = -q[23:0];
    end else begin
      if (ovf || q > QW'(23'h7F_FFFF)) res = 24'h7F_FFFF;
      else res = q[23:0];
    end
    return res;
  endfunction

  // ---------------- configuration ----------------
  logic [CFG_DATA_W-1:0] width_r;
  logic [CFG_DATA_W-1:0] height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  width_r  <= cfg_data;
        REG_SCREEN_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- stage enables ----------------
  logic en_p1, en_p2, en_p3, en_p4, en_p5;
  logic en_q1, en_q2, en_q3, en_q4, en_q5;
  logic en_r1, en_out;
  logic [QA:0] ena;
  logic [QB:0] enb;

  logic p1_v_r, p2_v_r, p3_v_r, p4_v_r, p5_v_r;
  logic q1_v_r, q2_v_r, q3_v_r, q4_v_r, q5_v_r;
  logic r1_v_r, out_valid_r;

  logic  a_v  [QA+1];
  lane_t a_l0 [QA+1];
  lane_t a_l1 [QA+1];
  side_t a_s  [QA+1];
  logic  b_v  [QB+1];
  lane_t b_l0 [QB+1];
  lane_t b_l1 [QB+1];
  side_t b_s  [QB+1];

  // A stage moves when it is empty or the stage after it moves.
  assign en_out  = !out_valid_r || !out_stall;
  assign en_r1   = !r1_v_r || en_out;
  assign enb[QB] = en_r1;
  assign en_q5   = !q5_v_r || enb[0];
  assign en_q4   = !q4_v_r || en_q5;
  assign en_q3   = !q3_v_r || en_q4;
  assign en_q2   = !q2_v_r || en_q3;
  assign en_q1   = !q1_v_r || en_q2;
  assign ena[QA] = en_q1;
  assign en_p5   = !p5_v_r || ena[0];
  assign en_p4   = !p4_v_r || en_p5;
  assign en_p3   = !p3_v_r || en_p4;
  assign en_p2   = !p2_v_r || en_p3;
  assign en_p1   = !p1_v_r || en_p2;
  assign in_stall = !en_p1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0; p2_v_r <= 1'b0; p3_v_r <= 1'b0; p4_v_r <= 1'b0;
      p5_v_r <= 1'b0; q1_v_r <= 1'b0; q2_v_r <= 1'b0; q3_v_r <= 1'b0;
      q4_v_r <= 1'b0; q5_v_r <= 1'b0; r1_v_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      if (en_p1)  p1_v_r      <= in_valid;
      if (en_p2)  p2_v_r      <= p1_v_r;
      if (en_p3)  p3_v_r      <= p2_v_r;
      if (en_p4)  p4_v_r      <= p3_v_r;
      if (en_p5)  p5_v_r      <= p4_v_r;
      if (en_q1)  q1_v_r      <= a_v[QA];
      if (en_q2)  q2_v_r      <= q1_v_r;
      if (en_q3)  q3_v_r      <= q2_v_r;
      if (en_q4)  q4_v_r      <= q3_v_r;
      if (en_q5)  q5_v_r      <= q4_v_r;
      if (en_r1)  r1_v_r      <= b_v[QB];
      if (en_out) out_valid_r <= r1_v_r;
    end
  end

  // ---------------- camera-space transform ----------------
  logic signed [31:0] p1_dx_r, p1_dy_r, p1_lx_r, p1_ly_r, p1_px_r, p1_py_r;
  logic signed [63:0] p2_det_a_r, p2_det_b_r, p2_lat_a_r, p2_lat_b_r;
  logic signed [63:0] p2_dep_a_r, p2_dep_b_r;
  logic [64:0]        p3_det_r, p3_nlat_r, p3_ndep_r;
  logic [63:0]        p4_udet_r, p4_ulat_r, p4_udep_r;
  logic               p4_neg_lat_r, p4_neg_dep_r, p4_detz_r;
  lane_t              p5_lane0_r, p5_lane1_r;
  side_t              p5_side_r;
  lane_t              p5_lane0_nxt, p5_lane1_nxt;
  side_t              p5_side_nxt;

  always_ff @(posedge clk) begin
    if (en_p1 && in_valid) begin
      p1_dx_r <= sat_diff(in_obj_x, in_cam_x);
      p1_dy_r <= sat_diff(in_obj_y, in_cam_y);
      p1_lx_r <= in_look_x;
      p1_ly_r <= in_look_y;
      p1_px_r <= in_plane_vec_x;
      p1_py_r <= in_plane_vec_y;
    end
    if (en_p2 && p1_v_r) begin
      p2_det_a_r <= p1_px_r * p1_ly_r;
      p2_det_b_r <= p1_lx_r * p1_py_r;
      p2_lat_a_r <= p1_ly_r * p1_dx_r;
      p2_lat_b_r <= p1_lx_r * p1_dy_r;
      p2_dep_a_r <= p1_px_r * p1_dy_r;
      p2_dep_b_r <= p1_py_r * p1_dx_r;
    end
    if (en_p3 && p2_v_r) begin
      p3_det_r  <= {p2_det_a_r[63], p2_det_a_r} - {p2_det_b_r[63], p2_det_b_r};
      p3_nlat_r <= {p2_lat_a_r[63], p2_lat_a_r} - {p2_lat_b_r[63], p2_lat_b_r};
      p3_ndep_r <= {p2_dep_a_r[63], p2_dep_a_r} - {p2_dep_b_r[63], p2_dep_b_r};
    end
    if (en_p4 && p3_v_r) begin
      p4_udet_r    <= mag65(p3_det_r);
      p4_ulat_r    <= mag65(p3_nlat_r);
      p4_udep_r    <= mag65(p3_ndep_r);
      p4_neg_lat_r <= p3_nlat_r[64] ^ p3_det_r[64];
      p4_neg_dep_r <= p3_ndep_r[64] ^ p3_det_r[64];
      p4_detz_r    <= (p3_det_r == 65'd0);
    end
    if (en_p5 && p4_v_r) begin
      p5_lane0_r <= p5_lane0_nxt;
      p5_lane1_r <= p5_lane1_nxt;
      p5_side_r  <= p5_side_nxt;
    end
  end

  // A quotient that needs more than QA bits saturates anyway.
  always_comb begin
    p5_lane0_nxt.rem = RW'(p4_ulat_r) << FRAC_BITS;
    p5_lane0_nxt.dvs = p4_udet_r;
    p5_lane0_nxt.quo = '0;
    p5_lane1_nxt.rem = RW'(p4_udep_r) << FRAC_BITS;
    p5_lane1_nxt.dvs = p4_udet_r;
    p5_lane1_nxt.quo = '0;
    p5_side_nxt.status = p4_detz_r ? ST_SINGULAR : ST_OK;
    p5_side_nxt.lat    = '0;
    p5_side_nxt.dep    = '0;
    p5_side_nxt.neg0   = p4_neg_lat_r;
    p5_side_nxt.neg1   = p4_neg_dep_r;
    p5_side_nxt.ovf0   = p5_lane0_nxt.rem >= (RW'(p4_udet_r) << QA);
    p5_side_nxt.ovf1   = p5_lane1_nxt.rem >= (RW'(p4_udet_r) << QA);
  end

  assign a_v[0]  = p5_v_r;
  assign a_l0[0] = p5_lane0_r;
  assign a_l1[0] = p5_lane1_r;
  assign a_s[0]  = p5_side_r;

  for (genvar j = 0; j < QA; j++) begin : g_cell_a
    assign ena[j] = !a_v[j+1] || ena[j+1];
    ssp_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (ena[j]),
      .sh      (SHW'(QA - 1 - j)),
      .vld_i   (a_v[j]),
      .lane0_i (a_l0[j]),
      .lane1_i (a_l1[j]),
      .side_i  (a_s[j]),
      .vld_o   (a_v[j+1]),
      .lane0_o (a_l0[j+1]),
      .lane1_o (a_l1[j+1]),
      .side_o  (a_s[j+1])
    );
  end

  // ---------------- projection setup ----------------
  logic [31:0]        q1_lat_r, q1_dep_r;
  status_t            q1_status_r;
  logic [31:0]        q1_lat_nxt, q1_dep_nxt;
  logic signed [31:0] q2_lat_r, q2_dep_r;
  logic signed [32:0] q2_sum_r;
  status_t            q2_status_r;
  logic signed [31:0] q3_lat_r, q3_dep_r;
  logic signed [45:0] q3_prod_r;
  status_t            q3_status_r;
  logic signed [12:0] w_half_s;
  logic [31:0]        q4_lat_r, q4_dep_r;
  logic [44:0]        q4_uprod_r;
  logic [31:0]        q4_udep_r;
  logic               q4_neg_r;
  status_t            q4_status_r;
  logic [45:0]        q4_prod_abs;
  logic [31:0]        q4_dep_abs;
  lane_t              q5_lane0_r, q5_lane1_r;
  side_t              q5_side_r;
  lane_t              q5_lane0_nxt, q5_lane1_nxt;
  side_t              q5_side_nxt;

  assign q1_lat_nxt = sat_q32(a_l0[QA].quo, a_s[QA].neg0, a_s[QA].ovf0);
  assign q1_dep_nxt = sat_q32(a_l1[QA].quo, a_s[QA].neg1, a_s[QA].ovf1);
  assign w_half_s   = $signed({1'b0, width_r[CFG_DATA_W-1:1]});
  assign q4_prod_abs = q3_prod_r[45] ? (~q3_prod_r + 46'd1) : q3_prod_r;
  assign q4_dep_abs  = q3_dep_r[31] ? (~q3_dep_r + 32'd1) : q3_dep_r;

  always_ff @(posedge clk) begin
    if (en_q1 && a_v[QA]) begin
      q1_lat_r <= q1_lat_nxt;
      q1_dep_r <= q1_dep_nxt;
      if (a_s[QA].status == ST_SINGULAR) q1_status_r <= ST_SINGULAR;
      else if (q1_dep_nxt == 32'd0)     q1_status_r <= ST_ZERO_DEPTH;
      else                              q1_status_r <= ST_OK;
    end
    if (en_q2 && q1_v_r) begin
      q2_lat_r    <= q1_lat_r;
      q2_dep_r    <= q1_dep_r;
      q2_sum_r    <= {q1_lat_r[31], q1_lat_r} + {q1_dep_r[31], q1_dep_r};
      q2_status_r <= q1_status_r;
    end
    if (en_q3 && q2_v_r) begin
      q3_lat_r    <= q2_lat_r;
      q3_dep_r    <= q2_dep_r;
      q3_prod_r   <= w_half_s * q2_sum_r;
      q3_status_r <= q2_status_r;
    end
    if (en_q4 && q3_v_r) begin
      q4_lat_r    <= q3_lat_r;
      q4_dep_r    <= q3_dep_r;
      q4_uprod_r  <= q4_prod_abs[44:0];
      q4_udep_r   <= q4_dep_abs;
      q4_neg_r    <= q3_prod_r[45] ^ q3_dep_r[31];
      q4_status_r <= q3_status_r;
    end
    if (en_q5 && q4_v_r) begin
      q5_lane0_r <= q5_lane0_nxt;
      q5_lane1_r <= q5_lane1_nxt;
      q5_side_r  <= q5_side_nxt;
    end
  end

  // Lane 0 gives the center column, lane 1 the span size.
  always_comb begin
    q5_lane0_nxt.rem = RW'(q4_uprod_r);
    q5_lane0_nxt.dvs = DVW'(q4_udep_r);
    q5_lane0_nxt.quo = '0;
    q5_lane1_nxt.rem = RW'(height_r) << FRAC_BITS;
    q5_lane1_nxt.dvs = DVW'(q4_udep_r);
    q5_lane1_nxt.quo = '0;
    q5_side_nxt.status = q4_status_r;
    q5_side_nxt.lat    = q4_lat_r;
    q5_side_nxt.dep    = q4_dep_r;
    q5_side_nxt.neg0   = q4_neg_r;
    q5_side_nxt.neg1   = 1'b0;
    q5_side_nxt.ovf0   = q5_lane0_nxt.rem >= (RW'(q4_udep_r) << QB);
    q5_side_nxt.ovf1   = q5_lane1_nxt.rem >= (RW'(q4_udep_r) << QB);
  end

  assign b_v[0]  = q5_v_r;
  assign b_l0[0] = q5_lane0_r;
  assign b_l1[0] = q5_lane1_r;
  assign b_s[0]  = q5_side_r;

  for (genvar j = 0; j < QB; j++) begin : g_cell_b
    assign enb[j] = !b_v[j+1] || enb[j+1];
    ssp_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (enb[j]),
      .sh      (SHW'(QB - 1 - j)),
      .vld_i   (b_v[j]),
      .lane0_i (b_l0[j]),
      .lane1_i (b_l1[j]),
      .side_i  (b_s[j]),
      .vld_o   (b_v[j+1]),
      .lane0_o (b_l0[j+1]),
      .lane1_o (b_l1[j+1]),
      .side_o  (b_s[j+1])
    );
  end

  // ---------------- saturation and clipping ----------------
  logic [23:0] r1_scr_r;
  logic [22:0] r1_span_r;
  logic [31:0] r1_lat_r, r1_dep_r;
  status_t     r1_status_r;

  always_ff @(posedge clk) begin
    if (en_r1 && b_v[QB]) begin
      r1_scr_r    <= sat_q24(b_l0[QB].quo, b_s[QB].neg0, b_s[QB].ovf0);
      if (b_s[QB].ovf1 || b_l1[QB].quo > QW'(23'h7F_FFFF)) r1_span_r <= 23'h7F_FFFF;
      else r1_span_r <= b_l1[QB].quo[22:0];
      r1_lat_r    <= b_s[QB].lat;
      r1_dep_r    <= b_s[QB].dep;
      r1_status_r <= b_s[QB].status;
    end
  end

  logic signed [24:0] half_s, hh_s, h_s, w_s, scr_s;
  logic signed [24:0] top_v, bot_v, left_v, right_v;
  logic [11:0]        top_nxt, bot_nxt;
  logic [22:0]        left_nxt;
  logic [23:0]        right_nxt;

  always_comb begin
    half_s = {3'd0, r1_span_r[22:1]};
    hh_s   = {13'd0, height_r[CFG_DATA_W-1:1]};
    h_s    = {12'd0, height_r};
    w_s    = {12'd0, width_r};
    scr_s  = {r1_scr_r[23], r1_scr_r};

    top_v   = hh_s - half_s;
    top_nxt = (top_v < 0) ? 12'd0 : top_v[11:0];

    bot_v = hh_s + half_s;
    if (bot_v >= h_s) bot_v = h_s - 25'sd1;
    if (bot_v < 0)            bot_nxt = 12'd0;
    else if (bot_v > 25'sd4095) bot_nxt = 12'd4095;
    else                      bot_nxt = bot_v[11:0];

    left_v   = scr_s - half_s;
    left_nxt = (left_v < 0) ? 23'd0 : left_v[22:0];

    right_v = scr_s + half_s;
    if (right_v >= w_s) right_v = w_s - 25'sd1;
    right_nxt = right_v[23:0];
  end

  logic [31:0] out_lat_r, out_dep_r;
  logic [23:0] out_scr_r, out_right_r;
  logic [22:0] out_span_r, out_left_r;
  logic [11:0] out_top_r, out_bot_r;
  status_t     out_status_r;

  always_ff @(posedge clk) begin
    if (en_out && r1_v_r) begin
      out_status_r <= r1_status_r;
      if (r1_status_r == ST_OK) begin
        out_lat_r   <= r1_lat_r;
        out_dep_r   <= r1_dep_r;
        out_scr_r   <= r1_scr_r;
        out_span_r  <= r1_span_r;
        out_top_r   <= top_nxt;
        out_bot_r   <= bot_nxt;
        out_left_r  <= left_nxt;
        out_right_r <= right_nxt;
      end else begin
        out_lat_r   <= '0;
        out_dep_r   <= '0;
        out_scr_r   <= '0;
        out_span_r  <= '0;
        out_top_r   <= '0;
        out_bot_r   <= '0;
        out_left_r  <= '0;
        out_right_r <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_lateral         = out_lat_r;
  assign out_depth           = out_dep_r;
  assign out_screen_center_x = out_scr_r;
  assign out_span_size       = out_span_r;
  assign out_top_row         = out_top_r;
  assign out_bottom_row      = out_bot_r;
  assign out_left_col        = out_left_r;
  assign out_right_col       = out_right_r;
  assign out_status          = out_status_r;

endmodule
